// ----- rtl/core/assert_macros.svh -----
// Assertion macros for the heap queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg)
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- rtl/core/mhq_pkg.sv -----
// ----------------------------------------------------------------------------
// mhq_pkg
// Shared types and constants of the min-heap priority queue.
// ----------------------------------------------------------------------------
`default_nettype none
package mhq_pkg;
    localparam int HeapDepthDef = 256;
    localparam int CoordBitsDef = 6;

    localparam logic [1:0] KIND_PUSH   = 2'd0;
    localparam logic [1:0] KIND_POP    = 2'd1;
    localparam logic [1:0] KIND_UPDATE = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_ABSENT = 2'd3;

    typedef struct packed {
        logic [1:0]              kind;
        logic [CoordBitsDef-1:0] pos_x;
        logic [CoordBitsDef-1:0] pos_y;
        logic [15:0]             cost;
    } cmd_t;

    typedef struct packed {
        logic [1:0]              status;
        logic [CoordBitsDef-1:0] out_x;
        logic [CoordBitsDef-1:0] out_y;
        logic [15:0]             out_cost;
        logic [8:0]              count;
    } res_t;
endpackage
`default_nettype wire

// ----- rtl/core/mhq_cmp.sv -----
// ----------------------------------------------------------------------------
// mhq_cmp
// Shared cost comparator: strict less-than between two operand costs.
// ----------------------------------------------------------------------------
`default_nettype none
module mhq_cmp (
    input  wire logic [15:0] a,
    input  wire logic [15:0] b,
    output logic             lt
);
    assign lt = a < b;
endmodule
`default_nettype wire

// ----- rtl/core/min_heap_priority_queue_decrease_key.sv -----
// ----------------------------------------------------------------------------
// min_heap_priority_queue_decrease_key
// Binary min-heap open list with a position-to-slot table for decrease-key.
// ----------------------------------------------------------------------------
//  channel   | signals                 | transaction
//  command   | start, busy, cmd        | start high while busy low
//  result    | done, res               | one cycle strobe, cannot stall
//
//  An error answer passes the look-up and decode states to done; a pop that
//  empties the heap also passes the last-entry state. Push, pop and update
//  read, compare and swap per heap level the entry moves, all through one heap
//  memory port and one cost comparator; an update sifts up, then down if the
//  entry did not move. Busy then drops. The receiver cannot stall.
//  After reset the presence table is swept clear, with busy held high.
`default_nettype none
module min_heap_priority_queue_decrease_key #(
    parameter int HEAP_DEPTH = mhq_pkg::HeapDepthDef
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire mhq_pkg::cmd_t  cmd,
    output logic                busy,
    output logic                done,
    output mhq_pkg::res_t       res
);
    import mhq_pkg::*;
    `include "assert_macros.svh"

    localparam int COORD_BITS = CoordBitsDef;
    localparam int AW = $clog2(HEAP_DEPTH);
    localparam int CW = $clog2(HEAP_DEPTH + 1);
    localparam int PW = 2 * COORD_BITS;
    localparam int CELLS = 1 << PW;
    localparam int EW = PW + 16;

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_LOOK  = 4'd2;
    localparam logic [3:0] S_DEC   = 4'd3;
    localparam logic [3:0] S_RDA   = 4'd4;
    localparam logic [3:0] S_RDB   = 4'd5;
    localparam logic [3:0] S_RDC   = 4'd6;
    localparam logic [3:0] S_CMP   = 4'd7;
    localparam logic [3:0] S_SWAP  = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;
    localparam logic [3:0] S_POPR  = 4'd10;
    localparam logic [3:0] S_POPL  = 4'd11;
    localparam logic [3:0] S_SWAP2 = 4'd12;

    // Heap memory entry: position (x,y) then cost.
    logic [EW-1:0] heap_mem [HEAP_DEPTH];
    logic [AW-1:0] slot_mem [CELLS];
    logic          pres_mem [CELLS];

    logic [3:0]    state_reg, state_next;
    logic [PW-1:0] clr_reg;
    cmd_t          cmd_reg;
    logic [CW-1:0] cnt_reg;
    logic [1:0]    status_reg;
    logic [EW-1:0] top_reg;
    logic          up_reg;       // sifting up, else down
    logic          moved_reg;    // update: sift up moved the entry
    logic [AW-1:0] p_reg;        // current slot
    logic [AW-1:0] q_reg;        // partner slot (parent or best child)
    logic [EW-1:0] ep_reg, eq_reg;
    logic          c1_lt_reg;    // first child cost below current cost
    logic          pres_rd;
    logic [AW-1:0] slot_rd;
    logic [EW-1:0] heap_rd;

    // Heap port.
    logic          h_we;
    logic [AW-1:0] h_wa, h_ra;
    logic [EW-1:0] h_wd;
    // Table ports.
    logic          t_we, p_we, p_wd;
    logic [PW-1:0] t_wa, p_wa, t_ra;
    logic [AW-1:0] t_wd;

    logic [PW-1:0] in_cell;
    logic [AW+1:0] c1, c2;
    logic [15:0]   cmp_a, cmp_b;
    logic          lt;

    assign in_cell = {cmd_reg.pos_x[COORD_BITS-1:0], cmd_reg.pos_y[COORD_BITS-1:0]};
    assign c1 = {1'b0, p_reg, 1'b1};
    assign c2 = {1'b0, p_reg, 1'b0} + (AW+2)'(2);

    always_ff @(posedge clk)
    begin
        if (h_we)
        begin
            heap_mem[h_wa] <= h_wd;
        end
        heap_rd <= heap_mem[h_ra];
        if (t_we)
        begin
            slot_mem[t_wa] <= t_wd;
        end
        slot_rd <= slot_mem[t_ra];
        if (p_we)
        begin
            pres_mem[p_wa] <= p_wd;
        end
        pres_rd <= pres_mem[t_ra];
    end

    mhq_cmp u_cmp (.a(cmp_a), .b(cmp_b), .lt(lt));

    always_comb
    begin
        state_next = state_reg;
        h_we = 1'b0; h_wa = p_reg; h_wd = ep_reg; h_ra = p_reg;
        t_we = 1'b0; t_wa = in_cell; t_wd = p_reg; t_ra = in_cell;
        p_we = 1'b0; p_wa = in_cell; p_wd = 1'b0;
        cmp_a = ep_reg[15:0]; cmp_b = eq_reg[15:0];
        unique case (state_reg)
            S_CLR:
            begin
                p_we = 1'b1; p_wa = clr_reg;
                if (clr_reg == PW'(CELLS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                h_ra = '0;
                state_next = S_DEC;
            end
            S_DEC:
            begin
                state_next = S_DONE;
                unique case (cmd_reg.kind)
                    KIND_PUSH:
                    begin
                        if (cnt_reg >= CW'(HEAP_DEPTH)) state_next = S_DONE;
                        else if (pres_rd) state_next = S_DONE;
                        else
                        begin
                            h_we = 1'b1; h_wa = cnt_reg[AW-1:0];
                            h_wd = {in_cell, cmd_reg.cost};
                            t_we = 1'b1; t_wd = cnt_reg[AW-1:0];
                            p_we = 1'b1; p_wd = 1'b1;
                            state_next = S_RDA;
                        end
                    end
                    KIND_POP:
                    begin
                        if (cnt_reg != '0)
                        begin
                            p_we = 1'b1; p_wa = heap_rd[EW-1:16];
                            h_ra = AW'(cnt_reg - CW'(1));
                            state_next = S_POPR;
                        end
                    end
                    KIND_UPDATE:
                    begin
                        if (pres_rd)
                        begin
                            h_ra = slot_rd;
                            state_next = S_POPL;
                        end
                    end
                    default: state_next = S_DONE;
                endcase
            end
            S_POPR:
            begin
                // Last entry is in heap_rd; place it at the root.
                if (cnt_reg == '0) state_next = S_DONE;
                else
                begin
                    h_we = 1'b1; h_wa = '0; h_wd = heap_rd;
                    t_we = 1'b1; t_wa = heap_rd[EW-1:16]; t_wd = '0;
                    state_next = S_RDA;
                end
            end
            S_POPL:
            begin
                // Updated entry in heap_rd; write the new cost.
                h_we = 1'b1; h_wa = p_reg;
                h_wd = {heap_rd[EW-1:16], cmd_reg.cost};
                state_next = S_RDA;
            end
            S_RDA:
            begin
                h_ra = p_reg;
                state_next = S_RDB;
            end
            S_RDB:
            begin
                h_ra = up_reg ? q_reg : c1[AW-1:0];
                state_next = S_RDC;
            end
            S_RDC:
            begin
                // First child cost against current cost, kept for the compare step.
                cmp_a = heap_rd[15:0]; cmp_b = ep_reg[15:0];
                h_ra = c2[AW-1:0];
                state_next = S_CMP;
            end
            S_CMP:
            begin
                // ep=current, eq=parent or child1, child2 arrives now.
                state_next = S_DONE;
                if (up_reg)
                begin
                    if (p_reg != '0 && lt) state_next = S_SWAP;
                    else if (cmd_reg.kind == KIND_UPDATE && !moved_reg)
                    begin
                        state_next = S_RDA;
                    end
                end
                else
                begin
                    cmp_a = heap_rd[15:0];
                    cmp_b = (c1 < (AW+2)'(cnt_reg) && c1_lt_reg) ? eq_reg[15:0]
                                                                  : ep_reg[15:0];
                    if (c1 < (AW+2)'(cnt_reg) && c1_lt_reg)
                    begin
                        state_next = S_SWAP;
                    end
                    if (c2 < (AW+2)'(cnt_reg) && lt) state_next = S_SWAP;
                end
            end
            S_SWAP:
            begin
                h_we = 1'b1; h_wa = q_reg; h_wd = ep_reg;
                t_we = 1'b1; t_wa = ep_reg[EW-1:16]; t_wd = q_reg;
                state_next = S_SWAP2;
            end
            S_SWAP2:
            begin
                h_we = 1'b1; h_wa = p_reg; h_wd = eq_reg;
                t_we = 1'b1; t_wa = eq_reg[EW-1:16]; t_wd = p_reg;
                state_next = S_RDA;
            end
            S_DONE: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            clr_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLR) clr_reg <= clr_reg + PW'(1);
            if (state_reg == S_DEC)
            begin
                if (state_next == S_RDA && cmd_reg.kind == KIND_PUSH)
                    cnt_reg <= cnt_reg + CW'(1);
                if (state_next == S_POPR) cnt_reg <= cnt_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                cmd_reg <= cmd; status_reg <= ST_OK; top_reg <= '0;
                moved_reg <= 1'b0;
            end
            S_DEC:
            begin
                unique case (cmd_reg.kind)
                    KIND_PUSH:
                    begin
                        if (cnt_reg >= CW'(HEAP_DEPTH)) status_reg <= ST_FULL;
                        else if (pres_rd) status_reg <= ST_ABSENT;
                        p_reg <= cnt_reg[AW-1:0]; up_reg <= 1'b1;
                    end
                    KIND_POP:
                    begin
                        if (cnt_reg == '0) status_reg <= ST_EMPTY;
                        else top_reg <= heap_rd;
                        p_reg <= '0; up_reg <= 1'b0;
                    end
                    KIND_UPDATE:
                    begin
                        if (!pres_rd) status_reg <= ST_ABSENT;
                        p_reg <= slot_rd; up_reg <= 1'b1;
                    end
                    default: status_reg <= ST_OK;
                endcase
            end
            S_RDB:
            begin
                ep_reg <= heap_rd;
            end
            S_RDC:
            begin
                eq_reg <= heap_rd;
                c1_lt_reg <= lt;
            end
            S_CMP:
            begin
                if (up_reg)
                begin
                    if (!(p_reg != '0 && lt)) up_reg <= 1'b0;
                end
                else if (c2 < (AW+2)'(cnt_reg) && lt)
                begin
                    eq_reg <= heap_rd; q_reg <= c2[AW-1:0];
                end
                else
                begin
                    q_reg <= c1[AW-1:0];
                end
            end
            S_SWAP2:
            begin
                p_reg <= q_reg;
                if (up_reg) moved_reg <= 1'b1;
            end
            default: ;
        endcase
        if (state_reg == S_RDA && up_reg)
        begin
            q_reg <= (p_reg - AW'(1)) >> 1;
        end
    end

    assign busy = state_reg != S_IDLE;
    assign done = state_reg == S_DONE;
    always_comb
    begin
        res.status   = status_reg;
        res.out_x    = top_reg[EW-1:16+COORD_BITS];
        res.out_y    = top_reg[16+COORD_BITS-1:16];
        res.out_cost = top_reg[15:0];
        res.count    = 9'(cnt_reg);
    end

    `CHK_IMPL(a_cnt_range, clk, rst_n, 1'b1, cnt_reg <= CW'(HEAP_DEPTH), "count over depth")
    `CHK_NEXT(a_done_idle, clk, rst_n, done, !busy, "done not followed by idle")
    `CHK_NEXT(a_start_busy, clk, rst_n, start && !busy, busy, "start not taken")
    `CHK_IMPL(a_pop_empty, clk, rst_n, done && res.status == ST_EMPTY, res.count == '0,
        "empty with entries")
endmodule
`default_nettype wire
